>>> hw/rtl/npsched_pkg.sv
`timescale 1ns / 1ps

package npsched_pkg;

  localparam int ID_W   = 8;
  localparam int PRIO_W = 8;
  localparam int TIME_W = 16;
  localparam int CT_W   = 23;
  localparam int SUM_W  = 29;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] burst;
  } job_t;

  // one classified request between the front and the back
  typedef struct packed {
    job_t job;
    logic keep;
    logic last;
  } q_entry_t;

endpackage

>>> hw/rtl/npsched_if.sv
`timescale 1ns / 1ps

interface npsched_in_if;
  logic                        valid;
  logic                        ready;
  logic [npsched_pkg::ID_W-1:0]   job_id;
  logic [npsched_pkg::PRIO_W-1:0] job_priority;
  logic [npsched_pkg::TIME_W-1:0] arrival_time;
  logic [npsched_pkg::TIME_W-1:0] burst_time;
  logic                        last_job;

  modport source (output valid, job_id, job_priority, arrival_time, burst_time, last_job,
                  input ready);
  modport sink (input valid, job_id, job_priority, arrival_time, burst_time, last_job,
                output ready);
endinterface

interface npsched_out_if;
  logic                          valid;
  logic                          ready;
  logic [npsched_pkg::ID_W-1:0]  done_job_id;
  logic [npsched_pkg::CT_W-1:0]  completion_time;
  logic [npsched_pkg::CT_W-1:0]  turnaround_time;
  logic [npsched_pkg::CT_W-1:0]  waiting_time;
  logic [npsched_pkg::SUM_W-1:0] sum_turnaround;
  logic [npsched_pkg::SUM_W-1:0] sum_waiting;
  logic                          final_result;

  modport source (output valid, done_job_id, completion_time, turnaround_time, waiting_time,
                  sum_turnaround, sum_waiting, final_result, input ready);
  modport sink (input valid, done_job_id, completion_time, turnaround_time, waiting_time,
                sum_turnaround, sum_waiting, final_result, output ready);
endinterface

>>> hw/rtl/npsched_front.sv
`timescale 1ns / 1ps

module npsched_front #(
  parameter int MAX_JOBS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  npsched_in_if.sink            in_ch,
  output logic                  push_valid,
  input  logic                  push_ready,
  output npsched_pkg::q_entry_t push_entry
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  logic [CNT_W-1:0] load_cnt_r;
  logic             accept;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign accept      = in_ch.valid & push_ready;

  always_comb begin
    push_entry.job.id    = in_ch.job_id;
    push_entry.job.prio  = in_ch.job_priority;
    push_entry.job.arr   = in_ch.arrival_time;
    push_entry.job.burst = in_ch.burst_time;
    // table full: the job is dropped but its last flag still closes the batch
    push_entry.keep      = (load_cnt_r < CNT_W'(MAX_JOBS));
    push_entry.last      = in_ch.last_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else if (accept) begin
      if (in_ch.last_job) begin
        load_cnt_r <= '0;
      end else if (push_entry.keep) begin
        load_cnt_r <= load_cnt_r + CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/npsched_fifo.sv
`timescale 1ns / 1ps

module npsched_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  npsched_pkg::q_entry_t push_entry,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output npsched_pkg::q_entry_t pop_entry
);

  npsched_pkg::q_entry_t slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       push;
  logic       pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

>>> hw/rtl/npsched_back.sv
`timescale 1ns / 1ps

module npsched_back #(
  parameter int MAX_JOBS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  npsched_pkg::q_entry_t pop_entry,
  npsched_out_if.source         out_ch
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CT_W  = npsched_pkg::CT_W;
  localparam int SUM_W = npsched_pkg::SUM_W;
  localparam int TIME_W = npsched_pkg::TIME_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_RUN    = 7'b0001000,
    S_TAT    = 7'b0010000,
    S_WT     = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t                    state_r;
  npsched_pkg::job_t         mem [MAX_JOBS];
  npsched_pkg::job_t         rd_data_r;
  npsched_pkg::job_t         best_job_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          scan_idx_r;
  logic [CNT_W-1:0]          fin_r;
  logic [IDX_W-1:0]          cmp_idx_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic                      cmp_vld_r;
  logic                      found_r;
  logic                      any_r;
  logic [TIME_W-1:0]         min_arr_r;
  logic [MAX_JOBS-1:0]       done_r;
  logic [CT_W-1:0]           sim_r;
  logic [CT_W-1:0]           tat_r;
  logic [CT_W-1:0]           wt_r;
  logic [SUM_W-1:0]          tot_tat_r;
  logic [SUM_W-1:0]          tot_wt_r;
  logic [SUM_W-1:0]          tot_wt_nxt;
  logic                      out_valid_r;
  logic                      out_load;
  logic                      is_final;
  logic                      mem_we;

  assign pop_ready  = (state_r == S_IDLE);
  assign mem_we     = pop_valid & pop_ready & pop_entry.keep;
  assign out_load   = (state_r == S_OUT) & (~out_valid_r | out_ch.ready);
  assign is_final   = ((fin_r + CNT_W'(1)) == cnt_r);
  assign tot_wt_nxt = tot_wt_r + {{(SUM_W-CT_W){1'b0}}, wt_r};
  assign out_ch.valid = out_valid_r;

  // job table, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IDX_W-1:0]] <= pop_entry.job;
    end
    rd_data_r <= mem[scan_idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fin_r       <= '0;
      scan_idx_r  <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      any_r       <= 1'b0;
      done_r      <= '0;
      sim_r       <= '0;
      tot_tat_r   <= '0;
      tot_wt_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            if (pop_entry.keep) cnt_r <= cnt_r + CNT_W'(1);
            if (pop_entry.last) begin
              state_r    <= S_SCAN;
              scan_idx_r <= '0;
              found_r    <= 1'b0;
              any_r      <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          cmp_vld_r <= (scan_idx_r < cnt_r);
          if (scan_idx_r < cnt_r) begin
            scan_idx_r <= scan_idx_r + CNT_W'(1);
            cmp_idx_r  <= scan_idx_r[IDX_W-1:0];
          end
          if (cmp_vld_r) begin
            if (!done_r[cmp_idx_r]) begin
              // strict compare keeps the earliest loaded job on a tie
              if (({{(CT_W-TIME_W){1'b0}}, rd_data_r.arr} <= sim_r) &&
                  (!found_r || (rd_data_r.prio < best_job_r.prio))) begin
                found_r    <= 1'b1;
                best_job_r <= rd_data_r;
                best_idx_r <= cmp_idx_r;
              end
              if (!any_r || (rd_data_r.arr < min_arr_r)) begin
                any_r     <= 1'b1;
                min_arr_r <= rd_data_r.arr;
              end
            end
            if (CNT_W'(cmp_idx_r) == (cnt_r - CNT_W'(1))) state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (found_r) begin
            state_r <= S_RUN;
          end else begin
            // nothing ready: jump to the earliest pending arrival and rescan
            sim_r      <= {{(CT_W-TIME_W){1'b0}}, min_arr_r};
            scan_idx_r <= '0;
            any_r      <= 1'b0;
            state_r    <= S_SCAN;
          end
        end
        S_RUN: begin
          sim_r              <= sim_r + {{(CT_W-TIME_W){1'b0}}, best_job_r.burst};
          done_r[best_idx_r] <= 1'b1;
          state_r            <= S_TAT;
        end
        S_TAT: begin
          tat_r   <= sim_r - {{(CT_W-TIME_W){1'b0}}, best_job_r.arr};
          state_r <= S_WT;
        end
        S_WT: begin
          wt_r      <= tat_r - {{(CT_W-TIME_W){1'b0}}, best_job_r.burst};
          tot_tat_r <= tot_tat_r + {{(SUM_W-CT_W){1'b0}}, tat_r};
          state_r   <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            if (is_final) begin
              cnt_r     <= '0;
              fin_r     <= '0;
              sim_r     <= '0;
              tot_tat_r <= '0;
              tot_wt_r  <= '0;
              done_r    <= '0;
              state_r   <= S_IDLE;
            end else begin
              tot_wt_r   <= tot_wt_nxt;
              fin_r      <= fin_r + CNT_W'(1);
              scan_idx_r <= '0;
              found_r    <= 1'b0;
              any_r      <= 1'b0;
              state_r    <= S_SCAN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.done_job_id     <= best_job_r.id;
      out_ch.completion_time <= sim_r;
      out_ch.turnaround_time <= tat_r;
      out_ch.waiting_time    <= wt_r;
      out_ch.sum_turnaround  <= tot_tat_r;
      out_ch.sum_waiting     <= tot_wt_nxt;
      out_ch.final_result    <= is_final;
    end
  end

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r != '0))
    else $error("scan started on an empty job table");

  a_fin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (fin_r < cnt_r))
    else $error("completed count reached job count while scheduling");

  a_pending_job: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DECIDE) && !found_r) |-> any_r)
    else $error("no unfinished job left while results are still owed");

  a_run_undone: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> !done_r[best_idx_r])
    else $error("picked job already completed");

endmodule

>>> hw/rtl/nonpreemptive_priority_scheduler_top.sv
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// in_ch     in   valid/ready        job_id, job_priority, arrival_time, burst_time, last_job
// out_ch    out  valid/ready        done_job_id, completion/turnaround/waiting time, sums, final
//
// loading takes one cycle per job while the queue has room; jobs past MAX_JOBS are dropped
// each completed job costs a table scan plus the decide/run/turnaround/waiting/output
// states; an idle gap adds a decide and a rescan
// the scan is bound by the single registered read port of the job table
// reset is synchronous; a two-entry queue lets loading continue while a result stalls
// a stalled result holds the back end; the front stalls once the queue is full

module nonpreemptive_priority_scheduler_top #(
  parameter int MAX_JOBS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  npsched_in_if.sink    in_ch,
  npsched_out_if.source out_ch
);

  logic                  push_valid;
  logic                  push_ready;
  npsched_pkg::q_entry_t push_entry;
  logic                  pop_valid;
  logic                  pop_ready;
  npsched_pkg::q_entry_t pop_entry;

  npsched_front #(.MAX_JOBS(MAX_JOBS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  npsched_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  npsched_back #(.MAX_JOBS(MAX_JOBS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_ch    (out_ch)
  );

endmodule
